// File: hw/rtl/elff_pkg.sv
`default_nettype none

package elff_pkg;

    localparam int DEPTH_DEF     = 32;
    localparam int TIME_BITS_DEF = 32;

    localparam int SRC_W   = 8;
    localparam int FAULT_W = 16;
    localparam int STAMP_W = 32;
    localparam int LEVEL_W = 6;

    typedef enum logic [1:0] {
        OP_PUSH     = 2'd0,
        OP_PUSH_NEW = 2'd1,
        OP_POP      = 2'd2,
        OP_LOOKUP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

endpackage

`default_nettype wire

// File: hw/rtl/elff_ram.sv
`default_nettype none

module elff_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/error_log_fifo_with_dedup.sv
// Sequence: a push goes through execute, head read and head wait, then raises its result
// strobe; a pop skips the head read. Push-if-absent and lookup first scan the stored records
// from the head (one record read per cycle, stops at the first match), or skip it when empty.
// Throughput: one transaction at a time; busy falls while the result strobe is high, so
// the next transaction can be taken while the strobe is high. The receiver cannot stall the strobe.
// Reset (synchronous, active low): FIFO empty, pointers zero, overwrite enabled.
`default_nettype none

module error_log_fifo_with_dedup
    import elff_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata,
    input  wire logic [1:0]         i_op,
    input  wire logic [SRC_W-1:0]   i_source_id,
    input  wire logic [FAULT_W-1:0] i_fault_code,
    input  wire logic [STAMP_W-1:0] i_time_stamp,
    output logic                    o_strobe,
    output logic [1:0]              o_status,
    output logic                    o_found,
    output logic                    o_dropped_oldest,
    output logic                    o_head_valid,
    output logic [SRC_W-1:0]        o_head_source,
    output logic [FAULT_W-1:0]      o_head_fault,
    output logic [STAMP_W-1:0]      o_head_time,
    output logic [LEVEL_W-1:0]      o_level,
    output logic                    o_is_empty,
    output logic                    o_is_full
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int RW = SRC_W + FAULT_W + TIME_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_HEAD_RD,
        S_HEAD_WAIT
    } t_state;

    t_state               r_state;
    logic                 r_ovw;
    t_op                  r_op;
    logic [SRC_W-1:0]     r_src;
    logic [FAULT_W-1:0]   r_fault;
    logic [TIME_BITS-1:0] r_time;
    logic [AW-1:0]        r_rd_ptr;
    logic [AW-1:0]        r_wr_ptr;
    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_scan_ptr;
    logic [CW-1:0]        r_scan_cnt;
    logic                 r_cmp_vld;
    logic                 r_found;
    logic                 r_hv;
    t_status              r_status;
    logic                 r_dropped;

    logic                 r_strobe;
    logic [1:0]           r_out_status;
    logic                 r_out_found;
    logic                 r_out_dropped;
    logic                 r_out_hv;
    logic [SRC_W-1:0]     r_out_src;
    logic [FAULT_W-1:0]   r_out_fault;
    logic [STAMP_W-1:0]   r_out_time;
    logic [LEVEL_W-1:0]   r_out_level;
    logic                 r_out_empty;
    logic                 r_out_full;

    logic [RW-1:0]        ram_rdata;
    logic [AW-1:0]        ram_raddr;
    logic                 ram_we;
    logic [SRC_W-1:0]     rd_src;
    logic [FAULT_W-1:0]   rd_fault;
    logic [TIME_BITS-1:0] rd_time;
    logic                 scan_hit;
    logic                 scan_more;
    logic                 fifo_full;
    logic                 push_ok;

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign rd_src    = ram_rdata[RW-1 -: SRC_W];
    assign rd_fault  = ram_rdata[TIME_BITS +: FAULT_W];
    assign rd_time   = ram_rdata[TIME_BITS-1:0];
    assign scan_hit  = r_cmp_vld && (rd_src == r_src) && (rd_fault == r_fault);
    assign scan_more = (r_scan_cnt != r_count);
    assign fifo_full = (r_count == CW'(DEPTH));
    assign push_ok   = ((r_op == OP_PUSH) || ((r_op == OP_PUSH_NEW) && !r_found))
                       && (!fifo_full || r_ovw);
    assign ram_raddr = (r_state == S_SCAN) ? r_scan_ptr : r_rd_ptr;
    assign ram_we    = (r_state == S_EXEC) && push_ok;

    elff_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata ({r_src, r_fault, r_time}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovw     <= 1'b1;
            r_rd_ptr  <= '0;
            r_wr_ptr  <= '0;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ovw <= i_cfg_wdata;
            end
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op       <= t_op'(i_op);
                        r_src      <= i_source_id;
                        r_fault    <= i_fault_code;
                        r_time     <= TIME_BITS'(i_time_stamp);
                        r_found    <= 1'b0;
                        r_scan_ptr <= r_rd_ptr;
                        r_scan_cnt <= '0;
                        r_cmp_vld  <= 1'b0;
                        if ((i_op inside {OP_PUSH_NEW, OP_LOOKUP}) && (r_count != '0)) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= scan_more;
                    if (scan_hit) begin
                        r_found <= 1'b1;
                        r_state <= S_EXEC;
                    end else if (!scan_more) begin
                        r_state <= S_EXEC;
                    end else begin
                        r_scan_ptr <= adv(r_scan_ptr);
                        r_scan_cnt <= r_scan_cnt + 1'b1;
                    end
                end
                S_EXEC: begin
                    r_status  <= ST_DONE;
                    r_dropped <= 1'b0;
                    r_hv      <= 1'b0;
                    r_state   <= S_HEAD_RD;
                    case (r_op)
                        OP_PUSH, OP_PUSH_NEW: begin
                            if ((r_op == OP_PUSH_NEW) && r_found) begin
                                r_status <= ST_DUP;
                            end else if (fifo_full && !r_ovw) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_wr_ptr <= adv(r_wr_ptr);
                                if (fifo_full) begin
                                    r_rd_ptr  <= adv(r_rd_ptr);
                                    r_dropped <= 1'b1;
                                end else begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                        end
                        OP_POP: begin
                            // popped record is read at the old head this cycle
                            r_state <= S_HEAD_WAIT;
                            if (r_count == '0) begin
                                r_status <= ST_EMPTY;
                            end else begin
                                r_rd_ptr <= adv(r_rd_ptr);
                                r_count  <= r_count - 1'b1;
                                r_hv     <= 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_HEAD_RD: begin
                    r_hv    <= (r_count != '0);
                    r_state <= S_HEAD_WAIT;
                end
                S_HEAD_WAIT: begin
                    r_strobe      <= 1'b1;
                    r_out_status  <= r_status;
                    r_out_found   <= r_found;
                    r_out_dropped <= r_dropped;
                    r_out_hv      <= r_hv;
                    r_out_src     <= r_hv ? rd_src : '0;
                    r_out_fault   <= r_hv ? rd_fault : '0;
                    r_out_time    <= r_hv ? STAMP_W'(rd_time) : '0;
                    r_out_level   <= LEVEL_W'(r_count);
                    r_out_empty   <= (r_count == '0);
                    r_out_full    <= fifo_full;
                    r_state       <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_strobe         = r_strobe;
    assign o_status         = r_out_status;
    assign o_found          = r_out_found;
    assign o_dropped_oldest = r_out_dropped;
    assign o_head_valid     = r_out_hv;
    assign o_head_source    = r_out_src;
    assign o_head_fault     = r_out_fault;
    assign o_head_time      = r_out_time;
    assign o_level          = r_out_level;
    assign o_is_empty       = r_out_empty;
    assign o_is_full        = r_out_full;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_is_empty |-> !o_head_valid || (o_status == ST_DONE && o_level == '0))
        else $error("head valid on empty fifo");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_dropped_oldest |-> o_is_full)
        else $error("oldest dropped while not full");
`endif

endmodule

`default_nettype wire
